[hdl/lpi_pkg.sv]
// ----------------------------------------------------------------------------
// lpi_pkg
// Shared widths, types and register codes of the line/plane intersection unit.
// ----------------------------------------------------------------------------
package lpi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = 66;
  localparam int MAG_W     = 64;
  localparam int Q_BITS    = 32;
  localparam int CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_A = 8'd0,
    REG_PLANE_B = 8'd1,
    REG_PLANE_C = 8'd2,
    REG_PLANE_D = 8'd3
  } lpi_reg_e;

  // Per-item values that ride along with the arithmetic.
  typedef struct packed {
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] pz;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic signed [DATA_W-1:0] vz;
    logic                     par;
    logic                     tneg;
  } lpi_side_t;

  // State of one division step.
  typedef struct packed {
    logic [MAG_W-1:0]  rem;
    logic [Q_BITS-1:0] quo;
    logic [MAG_W-1:0]  den;
    logic [MAG_W-1:0]  num;
    logic              big;
    lpi_side_t         side;
  } lpi_div_t;

endpackage

[hdl/lpi_div_stage.sv]
// ----------------------------------------------------------------------------
// lpi_div_stage
// One registered restoring-division step: shift in a numerator bit, subtract.
// ----------------------------------------------------------------------------
module lpi_div_stage import lpi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  logic     nbit_i,
  input  lpi_div_t data_i,
  output logic     valid_o,
  output lpi_div_t data_o
);

  logic            valid_q;
  lpi_div_t        data_q;
  lpi_div_t        data_d;
  logic [MAG_W:0]  shifted;
  logic [MAG_W:0]  diff;
  logic            ge;

  always_comb begin
    shifted = {data_i.rem, nbit_i};
    diff    = shifted - {1'b0, data_i.den};
    // sign of the difference tells whether the divisor fits
    ge      = ~diff[MAG_W];
    data_d      = data_i;
    data_d.rem  = ge ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
    data_d.quo  = {data_i.quo[Q_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hdl/line_plane_intersection_unit.sv]
// ----------------------------------------------------------------------------
// line_plane_intersection_unit
// Intersects lines with a configured plane, signed fixed point, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Write the plane coefficients A, B, C, D (indexes 0..3) on the cfg channel
//   while no item is in flight; other indexes are ignored. cfg_ready_o is
//   always high.
//   Each transfer on the slave stream carries a point and a direction; each
//   gives exactly one transfer on the master stream with the hit point in
//   tdata and the parallel/overflow flags in tuser, in input order.
//   From input transfer to m_axis_tvalid an item passes the product, sum,
//   magnitude and division setup stages, 32 one-bit division stages, then
//   the t stage, the t*v product stage and the output register.
//   Throughput is one item per cycle while s_axis_tready is high.
//   Reset clears all valid bits and loads the reset plane (z = 0).
//   When the receiver stalls, the output register holds and a skid register
//   takes one more result; s_axis_tready then drops until the skid drains.
// ----------------------------------------------------------------------------
module line_plane_intersection_unit import lpi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // cfg
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  // slave stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // point_x, point_y, point_z, dir_x, dir_y, dir_z
  input  logic [6*DATA_W-1:0]  s_axis_tdata,
  // master stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // hit_x, hit_y, hit_z
  output logic [3*DATA_W-1:0]  m_axis_tdata,
  // parallel, overflow
  output logic [1:0]           m_axis_tuser
);

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [Q_BITS-1:0]        Q_HALF = {1'b1, {(Q_BITS-1){1'b0}}};

  logic signed [DATA_W-1:0] plane_a_q, plane_b_q, plane_c_q, plane_d_q;
  logic en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_a_q <= '0;
      plane_b_q <= '0;
      plane_c_q <= DATA_W'(1) <<< FRAC_BITS;
      plane_d_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PLANE_A: plane_a_q <= cfg_data_i;
        REG_PLANE_B: plane_b_q <= cfg_data_i;
        REG_PLANE_C: plane_c_q <= cfg_data_i;
        REG_PLANE_D: plane_d_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- stage 1: products
  lpi_side_t side_in;
  assign side_in.px   = s_axis_tdata[0*DATA_W +: DATA_W];
  assign side_in.py   = s_axis_tdata[1*DATA_W +: DATA_W];
  assign side_in.pz   = s_axis_tdata[2*DATA_W +: DATA_W];
  assign side_in.vx   = s_axis_tdata[3*DATA_W +: DATA_W];
  assign side_in.vy   = s_axis_tdata[4*DATA_W +: DATA_W];
  assign side_in.vz   = s_axis_tdata[5*DATA_W +: DATA_W];
  assign side_in.par  = 1'b0;
  assign side_in.tneg = 1'b0;

  logic v1_q, v2_q, v3_q, v4_q, vt_q, vm_q;
  lpi_side_t s1_q, s2_q, s3_q, st_q, sm_q;
  logic signed [PROD_W-1:0] na_q, nb_q, nc_q, da_q, db_q, dc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= side_in;
      na_q <= plane_a_q * side_in.px;
      nb_q <= plane_b_q * side_in.py;
      nc_q <= plane_c_q * side_in.pz;
      da_q <= plane_a_q * side_in.vx;
      db_q <= plane_b_q * side_in.vy;
      dc_q <= plane_c_q * side_in.vz;
    end
  end

  // ---- stage 2: sums
  logic signed [ACC_W-1:0] num_q, den_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q  <= s1_q;
      num_q <= ACC_W'(na_q) + ACC_W'(nb_q) + ACC_W'(nc_q)
             + {{(ACC_W-DATA_W-FRAC_BITS){plane_d_q[DATA_W-1]}}, plane_d_q,
                {FRAC_BITS{1'b0}}};
      den_q <= ACC_W'(da_q) + ACC_W'(db_q) + ACC_W'(dc_q);
    end
  end

  // ---- stage 3: sign and magnitude
  logic [MAG_W-1:0] nmag_q, dmag_q;
  logic [ACC_W-1:0] nabs, dabs;
  lpi_side_t s3_d;

  always_comb begin
    nabs = num_q[ACC_W-1] ? ACC_W'(-num_q) : ACC_W'(num_q);
    dabs = den_q[ACC_W-1] ? ACC_W'(-den_q) : ACC_W'(den_q);
    s3_d      = s2_q;
    s3_d.par  = (den_q == '0);
    s3_d.tneg = ~(num_q[ACC_W-1] ^ den_q[ACC_W-1]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q   <= s3_d;
      nmag_q <= nabs[MAG_W-1:0];
      dmag_q <= dabs[MAG_W-1:0];
    end
  end

  // ---- stage 4: division setup; quotient is big when it needs more than Q_BITS
  lpi_div_t div_q [Q_BITS+1];
  logic     dv    [Q_BITS+1];
  lpi_div_t div_d;
  logic [MAG_W-1:0] rem_init;

  always_comb begin
    rem_init   = nmag_q >> (Q_BITS - FRAC_BITS);
    div_d.rem  = rem_init;
    div_d.quo  = '0;
    div_d.den  = dmag_q;
    div_d.num  = nmag_q;
    div_d.big  = (rem_init >= dmag_q);
    div_d.side = s3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0] <= div_d;
    end
  end

  assign dv[0] = v4_q;

  for (genvar k = 0; k < Q_BITS; k++) begin : g_div
    localparam int Bit = Q_BITS - 1 - k;
    logic nbit;
    if (Bit >= FRAC_BITS) begin : g_nb
      assign nbit = div_q[k].num[Bit-FRAC_BITS];
    end else begin : g_zero
      assign nbit = 1'b0;
    end
    lpi_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(dv[k]),
      .nbit_i (nbit),
      .data_i (div_q[k]),
      .valid_o(dv[k+1]),
      .data_o (div_q[k+1])
    );
  end

  // ---- t stage: sign and clamp
  logic signed [DATA_W-1:0] t_q, t_d;
  logic ovt_q, ovt_d;
  lpi_div_t dl;

  always_comb begin
    dl    = div_q[Q_BITS];
    ovt_d = 1'b0;
    if (dl.side.tneg) begin
      if (dl.big || dl.quo > Q_HALF) begin
        ovt_d = 1'b1;
        t_d   = S_MIN;
      end else begin
        t_d   = DATA_W'(-dl.quo);
      end
    end else begin
      if (dl.big || dl.quo >= Q_HALF) begin
        ovt_d = 1'b1;
        t_d   = S_MAX;
      end else begin
        t_d   = DATA_W'(dl.quo);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q  <= dl.side;
      t_q   <= t_d;
      ovt_q <= ovt_d;
    end
  end

  // ---- t*v products
  logic signed [PROD_W-1:0] mx_q, my_q, mz_q;
  logic ovm_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sm_q  <= st_q;
      ovm_q <= ovt_q;
      mx_q  <= t_q * st_q.vx;
      my_q  <= t_q * st_q.vy;
      mz_q  <= t_q * st_q.vz;
    end
  end

  // ---- valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vt_q <= 1'b0;
      vm_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vt_q <= dv[Q_BITS];
      vm_q <= vt_q;
    end
  end

  // ---- hit = p + floor(t*v), saturated
  function automatic logic [DATA_W:0] hit_sat(input logic signed [DATA_W-1:0] p,
                                              input logic signed [PROD_W-1:0] m);
    logic signed [PROD_W-1:0] sh;
    logic signed [PROD_W:0]   sum;
    logic [DATA_W:0]          res;
    sh  = m >>> FRAC_BITS;
    sum = (PROD_W+1)'(p) + (PROD_W+1)'(sh);
    if (sum > (PROD_W+1)'(S_MAX)) begin
      res = {1'b1, S_MAX};
    end else if (sum < (PROD_W+1)'(S_MIN)) begin
      res = {1'b1, S_MIN};
    end else begin
      res = {1'b0, sum[DATA_W-1:0]};
    end
    return res;
  endfunction

  logic [DATA_W:0]        hx, hy, hz;
  logic [3*DATA_W-1:0]    res_data;
  logic [1:0]             res_user;

  always_comb begin
    hx = hit_sat(sm_q.px, mx_q);
    hy = hit_sat(sm_q.py, my_q);
    hz = hit_sat(sm_q.pz, mz_q);
    if (sm_q.par) begin
      res_data = '0;
      res_user = 2'b01;
    end else begin
      res_data = {hz[DATA_W-1:0], hy[DATA_W-1:0], hx[DATA_W-1:0]};
      res_user = {ovm_q | hx[DATA_W] | hy[DATA_W] | hz[DATA_W], 1'b0};
    end
  end

  // ---- output register and skid
  logic                out_valid_q, skid_valid_q;
  logic [3*DATA_W-1:0] out_data_q, skid_data_q;
  logic [1:0]          out_user_q, skid_user_q;
  logic                out_free;

  assign en       = ~skid_valid_q;
  assign out_free = ~out_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= vm_q;
      end
    end else if (vm_q && en) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : res_data;
      out_user_q <= skid_valid_q ? skid_user_q : res_user;
    end else if (en) begin
      skid_data_q <= res_data;
      skid_user_q <= res_user;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

[hdl/lpi_checker.sv]
// ----------------------------------------------------------------------------
// lpi_checker
// Port-level checks of the line/plane intersection unit.
// ----------------------------------------------------------------------------
module lpi_checker import lpi_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [3*DATA_W-1:0] m_axis_tdata,
  input logic [1:0]          m_axis_tuser
);

  // parallel result carries a zero hit and no overflow
  a_parallel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
    else $error("parallel result not zero");

  // input side backs off only after the output stalled
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("tready dropped without output stall");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind line_plane_intersection_unit lpi_checker u_lpi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/sv/line_plane_intersection_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_plane_intersection_unit_tb
// Drives line queries and plane writes into the unit and checks every hit point
// and flag against a bit-exact fixed-point predictor or a given expected hit.
// ----------------------------------------------------------------------------
module line_plane_intersection_unit_tb import lpi_pkg::*; ();

  localparam int LATENCY     = 39;
  localparam int RAND_ITEMS  = 1850;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [DATA_W-1:0] hx;
    logic signed [DATA_W-1:0] hy;
    logic signed [DATA_W-1:0] hz;
    logic                     par;
    logic                     ovf;
  } hit_t;

  typedef struct {
    logic [DATA_W-1:0] p[3];
    logic [DATA_W-1:0] v[3];
    logic              known;
    hit_t              hit;
  } query_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [6*DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [3*DATA_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  line_plane_intersection_unit u_top (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // plane coefficients as seen by the predictor
  logic signed [DATA_W-1:0] coef_a = 0, coef_b = 0, coef_c = 32'sd65536, coef_d = 0;
  hit_t pending_hits[$];
  int   mismatches = 0;
  int   send_idle = 0, recv_idle = 0;
  longint cycles = 0;

  function automatic hit_t predict_hit(logic [DATA_W-1:0] p[3], logic [DATA_W-1:0] v[3]);
    logic signed [ACC_W+FRAC_BITS+2:0] num, den, nm, dm, tq;
    logic signed [ACC_W+FRAC_BITS+2:0] tv, h;
    logic signed [ACC_W+FRAC_BITS+2:0] tval;
    logic signed [DATA_W-1:0] ps[3], vs[3];
    hit_t r;
    int i;
    for (i = 0; i < 3; i++) begin
      ps[i] = p[i];
      vs[i] = v[i];
    end
    num = coef_a * ps[0] + coef_b * ps[1] + coef_c * ps[2]
          + (coef_d <<< FRAC_BITS);
    den = coef_a * vs[0] + coef_b * vs[1] + coef_c * vs[2];
    r = '0;
    if (den == 0) begin
      r.par = 1'b1;
      return r;
    end
    nm = num < 0 ? -num : num;
    dm = den < 0 ? -den : den;
    tq = (nm <<< FRAC_BITS) / dm;
    tval = ((num < 0) != (den < 0)) ? tq : -tq;
    if (tval > 64'sh7FFFFFFF) begin
      tval = 64'sh7FFFFFFF;
      r.ovf = 1'b1;
    end else if (tval < -64'sh80000000) begin
      tval = -64'sh80000000;
      r.ovf = 1'b1;
    end
    for (i = 0; i < 3; i++) begin
      tv = tval * vs[i];
      h = ps[i] + (tv >>> FRAC_BITS);
      if (h > 64'sh7FFFFFFF) begin
        h = 64'sh7FFFFFFF;
        r.ovf = 1'b1;
      end else if (h < -64'sh80000000) begin
        h = -64'sh80000000;
        r.ovf = 1'b1;
      end
      if (i == 0) r.hx = h[DATA_W-1:0];
      else if (i == 1) r.hy = h[DATA_W-1:0];
      else r.hz = h[DATA_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("line_plane_intersection_unit_tb failed");
      $finish;
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // compare each output transfer against the oldest expectation
  always @(posedge clk_i) begin
    hit_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[DATA_W-1:0], m_axis_tdata[2*DATA_W-1:DATA_W],
             m_axis_tdata[3*DATA_W-1:2*DATA_W], m_axis_tuser[0], m_axis_tuser[1]};
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_hits.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  task automatic write_plane(lpi_reg_e idx, logic [DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_PLANE_A: coef_a = val;
      REG_PLANE_B: coef_b = val;
      REG_PLANE_C: coef_c = val;
      REG_PLANE_D: coef_d = val;
      default: ;
    endcase
  endtask

  task automatic write_ignored(logic [CFG_IDX_W-1:0] idx);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= $urandom;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_hits();
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  // one transfer; valid stays high across back-to-back items
  task automatic send_query(query_t q);
    hit_t e;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {q.v[2], q.v[1], q.v[0], q.p[2], q.p[1], q.p[0]};
    do @(posedge clk_i); while (!s_axis_tready);
    e = q.known ? q.hit : predict_hit(q.p, q.v);
    pending_hits.push_back(e);
  endtask

  function automatic logic [DATA_W-1:0] rand_val();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      2: return 32'($signed($urandom_range(8)) - 4) <<< 16;
      3: return 32'($signed($urandom_range(2000)) - 1000) <<< 8;
      4: return 32'h0;
      default: return $signed($urandom) >>> $urandom_range(20);
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int i;
    for (i = 0; i < 3; i++) begin
      q.p[i] = rand_val();
      q.v[i] = rand_val();
    end
    q.known = 1'b0;
    q.hit = '0;
    return q;
  endfunction

  function automatic query_t row(logic [DATA_W-1:0] px, py, pz, vx, vy, vz,
                                 logic known, hit_t hit);
    query_t q;
    q.p[0] = px; q.p[1] = py; q.p[2] = pz;
    q.v[0] = vx; q.v[1] = vy; q.v[2] = vz;
    q.known = known;
    q.hit = hit;
    return q;
  endfunction

  initial begin
    query_t directed[$];
    int phase, n, k;
    // reset plane is z = 0
    directed.push_back(row(32'h10000, 32'h20000, 32'h30000, 0, 0, 32'h10000,
                           1, '{32'h10000, 32'h20000, 0, 0, 0}));
    directed.push_back(row(5, 6, 7, 32'h10000, 0, 0, 1, '{0, 0, 0, 1, 0}));
    directed.push_back(row(32'h50000, 32'h60000, 0, 1, 1, 1,
                           1, '{32'h50000, 32'h60000, 0, 0, 0}));
    directed.push_back(row(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                           32'h80000000, 32'h7FFFFFFF, 1, 0, '0));
    directed.push_back(row(0, 0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                           32'h80000000, 0, '0));
    directed.push_back(row(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                           32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, '0));
    directed.push_back(row(0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1, 0, '0));
    directed.push_back(row(0, 0, 32'h10000, 32'h10000, 0, 32'hFFFF0000, 0, '0));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    foreach (directed[i]) send_query(directed[i]);
    s_axis_tvalid <= 1'b0;
    drain_hits();

    // extreme planes
    write_plane(REG_PLANE_A, 32'h7FFFFFFF);
    write_plane(REG_PLANE_B, 32'h80000000);
    write_plane(REG_PLANE_C, 32'h80000000);
    write_plane(REG_PLANE_D, 32'h7FFFFFFF);
    write_ignored(8'd4);
    write_ignored(8'hFF);
    for (k = 0; k < 12; k++) send_query(rand_query());
    s_axis_tvalid <= 1'b0;
    drain_hits();

    n = 0;
    for (phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 22 : (phase == 1) ? 55 : 0;
      recv_idle = (phase == 0) ? 55 : (phase == 1) ? 22 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        write_plane(REG_PLANE_A, rand_val());
        write_plane(REG_PLANE_B, rand_val());
        write_plane(REG_PLANE_C, rand_val());
        write_plane(REG_PLANE_D, rand_val());
        if ($urandom_range(3) == 0) write_ignored(8'($urandom_range(255, 4)));
        for (k = 0; k < RAND_ITEMS / 12; k++) begin
          send_query(rand_query());
          n++;
        end
        s_axis_tvalid <= 1'b0;
        drain_hits();
      end
    end

    if (mismatches == 0) begin
      $display("line_plane_intersection_unit_tb passed");
    end else begin
      $display("line_plane_intersection_unit_tb failed");
    end
    $finish;
  end

endmodule
